>>> design/part_classifier_queue_unit_defines.svh
// Assertion helpers used by part_classifier_queue_unit.
`ifndef PART_CLASSIFIER_QUEUE_UNIT_DEFINES_SVH
`define PART_CLASSIFIER_QUEUE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pcq_pkg.sv
package pcq_pkg;

    localparam int DEF_QUEUE_DEPTH = 1024;

    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 10;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 2;
    localparam int WIDE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CLASSES = 4;

    localparam logic [WIDE_W-1:0] WIDE_MAX = 16'hFFFF;

    // threshold reset values
    localparam logic [THR_W-1:0] RST_ALU_MAX   = 10'd200;
    localparam logic [THR_W-1:0] RST_STEEL_MIN = 10'd201;
    localparam logic [THR_W-1:0] RST_STEEL_MAX = 10'd799;
    localparam logic [THR_W-1:0] RST_WHITE_MIN = 10'd800;
    localparam logic [THR_W-1:0] RST_WHITE_MAX = 10'd969;
    localparam logic [THR_W-1:0] RST_BLACK_MIN = 10'd970;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE     = 3'd0,
        CLS_BLACK    = 3'd1,
        CLS_ALUMINUM = 3'd2,
        CLS_WHITE    = 3'd3,
        CLS_STEEL    = 3'd4
    } pcq_class_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_HALTED  = 2'd1,
        ST_DROPPED = 2'd2
    } pcq_status_t;

    typedef enum logic [OP_W-1:0] {
        OP_WINDOW   = 2'd0,
        OP_SAMPLE   = 2'd1,
        OP_EXIT     = 2'd2,
        OP_RESERVED = 2'd3
    } pcq_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALU_MAX   = 3'd0,
        CFG_STEEL_MIN = 3'd1,
        CFG_STEEL_MAX = 3'd2,
        CFG_WHITE_MIN = 3'd3,
        CFG_WHITE_MAX = 3'd4,
        CFG_BLACK_MIN = 3'd5
    } pcq_cfg_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } pcq_state_t;

    typedef struct packed {
        logic [THR_W-1:0] alu_max;
        logic [THR_W-1:0] steel_min;
        logic [THR_W-1:0] steel_max;
        logic [THR_W-1:0] white_min;
        logic [THR_W-1:0] white_max;
        logic [THR_W-1:0] black_min;
    } pcq_thresh_t;

endpackage

>>> design/part_classifier_queue_unit.sv
// Channel   | Dir | Handshake                         | Signals
// ----------+-----+-----------------------------------+------------------------------------
// command   | in  | transfer when start && !busy      | operation, sample_value
// result    | out | done strobe, one cycle, no stall  | target_part .. fault_reading
// config    | in  | write when cfg_we, no wait        | cfg_index, cfg_data
//
// Per item: the transfer edge issues the queue read at the read pointer;
// the exec cycle (busy high) uses the registered read data, updates state and writes
// the queue; done follows, and the next transfer can land in that done cycle. The
// registered read of the queue memory is why each item needs an exec cycle.
// Reset: control and counters clear at once; queue data is only used below the fill level.
// Stalls: the result receiver cannot stall; busy is the only back pressure.
`include "part_classifier_queue_unit_defines.svh"

module part_classifier_queue_unit #(
    parameter int QUEUE_DEPTH = pcq_pkg::DEF_QUEUE_DEPTH,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic [pcq_pkg::OP_W-1:0]      operation,
    input  logic [pcq_pkg::SAMPLE_W-1:0]  sample_value,

    input  logic                          cfg_we,
    input  logic [pcq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcq_pkg::THR_W-1:0]     cfg_data,

    output logic                          done,
    output logic [pcq_pkg::CLASS_W-1:0]   target_part,
    output logic [pcq_pkg::CLASS_W-1:0]   classified_part,
    output logic [pcq_pkg::STATUS_W-1:0]  status,
    output logic [CNT_W-1:0]              queue_count,
    output logic [pcq_pkg::WIDE_W-1:0]    black_count,
    output logic [pcq_pkg::WIDE_W-1:0]    aluminum_count,
    output logic [pcq_pkg::WIDE_W-1:0]    white_count,
    output logic [pcq_pkg::WIDE_W-1:0]    steel_count,
    output logic [pcq_pkg::WIDE_W-1:0]    calibration_low,
    output logic [pcq_pkg::WIDE_W-1:0]    calibration_high,
    output logic [pcq_pkg::WIDE_W-1:0]    fault_reading
);
    import pcq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_IDX   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(QUEUE_DEPTH);

    // ---------------------------------------------------------------- control
    pcq_state_t state_reg, state_next;
    logic       accept;
    logic       exec;

    // ---------------------------------------------------------------- config
    pcq_thresh_t thresh_reg;

    // ---------------------------------------------------------------- state
    pcq_op_t             op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic                window_reg;
    logic [WIDE_W-1:0]   run_min_reg;
    logic [WIDE_W-1:0]   lowest_reg;
    logic [THR_W-1:0]    highest_reg;
    logic [WIDE_W-1:0]   cnt_reg [NUM_CLASSES];
    logic                halted_reg;
    logic [THR_W-1:0]    bad_reg;

    // per-item result registers
    logic        done_reg;
    pcq_class_t  target_reg;
    pcq_class_t  enq_reg;
    pcq_status_t status_reg;

    // ---------------------------------------------------------------- datapath nets
    logic [THR_W-1:0]   new_min;
    pcq_class_t         cls;
    logic [CLASS_W-1:0] mem_rd_data;
    pcq_class_t         pop_cls;
    logic [1:0]         pop_idx;
    logic               active;
    logic               closed_sample;
    logic               halt_now;
    logic               push;
    logic               drop;
    logic               pop;
    logic               queue_full;
    pcq_class_t         res_target;
    pcq_class_t         res_enq;
    pcq_status_t        res_status;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        accept     = 1'b0;
        exec       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                accept = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy       = 1'b1;
                exec       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.alu_max   <= RST_ALU_MAX;
            thresh_reg.steel_min <= RST_STEEL_MIN;
            thresh_reg.steel_max <= RST_STEEL_MAX;
            thresh_reg.white_min <= RST_WHITE_MIN;
            thresh_reg.white_max <= RST_WHITE_MAX;
            thresh_reg.black_min <= RST_BLACK_MIN;
        end
        else if (cfg_we)
        begin
            unique case (pcq_cfg_t'(cfg_index))
                CFG_ALU_MAX:   thresh_reg.alu_max   <= cfg_data;
                CFG_STEEL_MIN: thresh_reg.steel_min <= cfg_data;
                CFG_STEEL_MAX: thresh_reg.steel_max <= cfg_data;
                CFG_WHITE_MIN: thresh_reg.white_min <= cfg_data;
                CFG_WHITE_MAX: thresh_reg.white_max <= cfg_data;
                CFG_BLACK_MIN: thresh_reg.black_min <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= pcq_op_t'(operation);
            sample_reg <= sample_value;
        end
    end

    // ---------------------------------------------------------------- class queue
    // Read is issued on every transfer; the write lands at the end of the exec
    // cycle, and busy keeps the next read from being issued until after that write,
    // so a pop always sees the latest push without forwarding.
    pcq_queue_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_queue_mem (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (CLASS_W'(cls)),
        .rd_en   (accept),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rd_data)
    );

    // new running minimum; a sample is at most 10 bits so the result fits
    assign new_min = ({{(WIDE_W-SAMPLE_W){1'b0}}, sample_reg} < run_min_reg)
                   ? sample_reg : run_min_reg[THR_W-1:0];

    pcq_classifier u_classifier (
        .thresh (thresh_reg),
        .value  (new_min),
        .cls    (cls)
    );

    always_comb
    begin
        case (mem_rd_data) inside
            CLS_BLACK, CLS_ALUMINUM, CLS_WHITE, CLS_STEEL:
            begin
                pop_cls = pcq_class_t'(mem_rd_data);
            end
            default:
            begin
                pop_cls = CLS_NONE;
            end
        endcase
    end

    assign pop_idx       = 2'(CLASS_W'(pop_cls) - CLASS_W'(1));
    assign queue_full    = (fill_reg >= FULL_LEVEL);
    assign active        = exec && !halted_reg;
    assign closed_sample = active && (op_reg == OP_SAMPLE) && !window_reg;
    assign halt_now      = closed_sample && (cls == CLS_NONE);
    assign push          = closed_sample && (cls != CLS_NONE) && !queue_full;
    assign drop          = closed_sample && (cls != CLS_NONE) && queue_full;
    assign pop           = active && (op_reg == OP_EXIT) && (fill_reg != '0);

    always_comb
    begin
        res_target = pop ? pop_cls : CLS_NONE;
        res_enq    = push ? cls : CLS_NONE;
        if (halted_reg || halt_now)
        begin
            res_status = ST_HALTED;
        end
        else if (drop)
        begin
            res_status = ST_DROPPED;
        end
        else
        begin
            res_status = ST_OK;
        end
    end

    // ---------------------------------------------------------------- state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            window_reg  <= 1'b0;
            run_min_reg <= '0;
            lowest_reg  <= WIDE_MAX;
            highest_reg <= '0;
            halted_reg  <= 1'b0;
            bad_reg     <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (active)
        begin
            case (op_reg)
                OP_WINDOW:
                begin
                    window_reg <= !window_reg;
                    if (!window_reg)
                    begin
                        run_min_reg <= WIDE_MAX;
                    end
                end
                OP_SAMPLE:
                begin
                    run_min_reg <= WIDE_W'(new_min);
                    if (!window_reg)
                    begin
                        if (WIDE_W'(new_min) < lowest_reg)
                        begin
                            lowest_reg <= WIDE_W'(new_min);
                        end
                        if (new_min > highest_reg)
                        begin
                            highest_reg <= new_min;
                        end
                        if (halt_now)
                        begin
                            halted_reg <= 1'b1;
                            bad_reg    <= new_min;
                        end
                        else if (push)
                        begin
                            wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                            fill_reg   <= fill_reg + 1'b1;
                        end
                    end
                end
                OP_EXIT:
                begin
                    if (pop)
                    begin
                        if (pop_cls != CLS_NONE && cnt_reg[pop_idx] != WIDE_MAX)
                        begin
                            cnt_reg[pop_idx] <= cnt_reg[pop_idx] + 1'b1;
                        end
                        rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
                        fill_reg   <= fill_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            target_reg <= res_target;
            enq_reg    <= res_enq;
            status_reg <= res_status;
        end
    end

    // state outputs stay put through the done cycle: the next item can only
    // change them at the end of its own exec cycle
    assign done             = done_reg;
    assign target_part      = CLASS_W'(target_reg);
    assign classified_part  = CLASS_W'(enq_reg);
    assign status           = STATUS_W'(status_reg);
    assign queue_count      = fill_reg;
    assign black_count      = cnt_reg[0];
    assign aluminum_count   = cnt_reg[1];
    assign white_count      = cnt_reg[2];
    assign steel_count      = cnt_reg[3];
    assign calibration_low  = lowest_reg;
    assign calibration_high = WIDE_W'(highest_reg);
    assign fault_reading    = WIDE_W'(bad_reg);

    // ---------------------------------------------------------------- checks
    `PCQ_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FULL_LEVEL, "fill above depth")
    `PCQ_ASSERT_NEXT(a_done_after_exec, clk, rst_n, state_reg == S_EXEC, done_reg, "no done")
    `PCQ_ASSERT_NEXT(a_halt_freezes, clk, rst_n, halted_reg, halted_reg && $stable(fill_reg), "halt lost")
    `PCQ_ASSERT_SAME(a_bad_status_no_class, clk, rst_n, done_reg && status_reg != ST_OK, target_reg == CLS_NONE && enq_reg == CLS_NONE, "class on fault")

endmodule

>>> design/pcq_queue_mem.sv
module pcq_queue_mem #(
    parameter int DEPTH  = pcq_pkg::DEF_QUEUE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [pcq_pkg::CLASS_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [pcq_pkg::CLASS_W-1:0] rd_data
);
    import pcq_pkg::*;

    logic [CLASS_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, enabled by rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/pcq_classifier.sv
module pcq_classifier (
    input  pcq_pkg::pcq_thresh_t      thresh,
    input  logic [pcq_pkg::THR_W-1:0] value,
    output pcq_pkg::pcq_class_t       cls
);
    import pcq_pkg::*;

    // bands tested in priority order: black, white, steel, aluminum
    always_comb
    begin
        if (value >= thresh.black_min)
        begin
            cls = CLS_BLACK;
        end
        else if (value >= thresh.white_min && value <= thresh.white_max)
        begin
            cls = CLS_WHITE;
        end
        else if (value >= thresh.steel_min && value <= thresh.steel_max)
        begin
            cls = CLS_STEEL;
        end
        else if (value <= thresh.alu_max)
        begin
            cls = CLS_ALUMINUM;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

endmodule
